@@ src/kmd_pkg.sv @@
// Shared types, codes and the fixed key table of the key-matrix decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package kmd_pkg;

  // Special table characters
  localparam logic [6:0] CH_ENTER = 7'h13;
  localparam logic [6:0] CH_BKSP  = 7'h1d;
  localparam logic [6:0] CH_FN    = 7'h14;
  localparam logic [6:0] CH_SHIFT = 7'h1c;

  // Navigation lane numbers (nav_held and deadline order)
  localparam logic [1:0] NAV_NEXT = 2'd0;
  localparam logic [1:0] NAV_PREV = 2'd1;
  localparam logic [1:0] NAV_UP   = 2'd2;
  localparam logic [1:0] NAV_DOWN = 2'd3;
  localparam int unsigned NAV_LANES = 4;

  // Bit positions in the per-poll pulse register
  localparam int unsigned PP_SEL = 4;
  localparam int unsigned PP_ESC = 5;
  localparam int unsigned PP_KEY = 6;
  localparam int unsigned PP_W   = 7;

  // Configuration registers
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD = 2'd1;
  localparam logic [15:0] RESET_REPEAT_START  = 16'd350;
  localparam logic [15:0] RESET_REPEAT_PERIOD = 16'd150;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    CLS_DROP,
    CLS_FN,
    CLS_SHIFT,
    CLS_CHAR,
    CLS_POLL
  } kmd_class_e;

  typedef struct packed {
    logic [6:0] plain;
    logic [6:0] shifted;
    logic [6:0] alt;
  } kmd_cell_t;

  typedef struct packed {
    kmd_class_e  cls;
    kmd_cell_t   slot;
    logic        pressed;
    logic [31:0] now_ms;
    logic        select_held;
    logic        wake_swallow;
  } kmd_item_t;

  // Result payload, char_code in the lowest bits
  typedef struct packed {
    logic       any_press;
    logic       clear_keys;
    logic       key_pulse;
    logic       esc_pulse;
    logic       sel_pulse;
    logic       down_pulse;
    logic       up_pulse;
    logic       prev_pulse;
    logic       next_pulse;
    logic       fn_mod;
    logic [6:0] char_code;
  } kmd_result_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] lane;
  } kmd_nav_t;

  // Fixed 8x16 key table; cells not listed are empty.
  function automatic kmd_cell_t key_cell(input logic [2:0] row, input logic [3:0] col);
    kmd_cell_t c;
    c = '{7'h00, 7'h00, 7'h00};
    case ({row, col})
      7'h00: c = '{7'h71, 7'h51, 7'h31};
      7'h01: c = '{7'h77, 7'h57, 7'h32};
      7'h02: c = '{7'h65, 7'h45, 7'h33};
      7'h03: c = '{7'h72, 7'h52, 7'h34};
      7'h04: c = '{7'h74, 7'h54, 7'h35};
      7'h05: c = '{7'h79, 7'h59, 7'h36};
      7'h06: c = '{7'h75, 7'h55, 7'h37};
      7'h07: c = '{7'h69, 7'h49, 7'h38};
      7'h08: c = '{7'h6f, 7'h4f, 7'h39};
      7'h09: c = '{7'h70, 7'h50, 7'h30};
      7'h10: c = '{7'h61, 7'h41, 7'h2a};
      7'h11: c = '{7'h73, 7'h53, 7'h2f};
      7'h12: c = '{7'h64, 7'h44, 7'h2b};
      7'h13: c = '{7'h66, 7'h46, 7'h2d};
      7'h14: c = '{7'h67, 7'h47, 7'h3d};
      7'h15: c = '{7'h68, 7'h48, 7'h3a};
      7'h16: c = '{7'h6a, 7'h4a, 7'h27};
      7'h17: c = '{7'h6b, 7'h4b, 7'h22};
      7'h18: c = '{7'h6c, 7'h4c, 7'h40};
      7'h19: c = '{CH_ENTER, CH_ENTER, CH_ENTER};
      7'h20: c = '{CH_FN, CH_FN, CH_FN};
      7'h21: c = '{7'h7a, 7'h5a, 7'h5f};
      7'h22: c = '{7'h78, 7'h58, 7'h24};
      7'h23: c = '{7'h63, 7'h43, 7'h3b};
      7'h24: c = '{7'h76, 7'h56, 7'h3f};
      7'h25: c = '{7'h62, 7'h42, 7'h21};
      7'h26: c = '{7'h6e, 7'h4e, 7'h2c};
      7'h27: c = '{7'h6d, 7'h4d, 7'h2e};
      7'h28: c = '{CH_SHIFT, CH_SHIFT, 7'h00};
      7'h29: c = '{CH_BKSP, CH_BKSP, CH_BKSP};
      7'h30: c = '{7'h20, 7'h20, 7'h20};
      default: c = '{7'h00, 7'h00, 7'h00};
    endcase
    return c;
  endfunction

  // d/a/w/s drive next/prev/up/down
  function automatic kmd_nav_t nav_decode(input logic [6:0] ch);
    kmd_nav_t n;
    n = '{1'b0, NAV_NEXT};
    case (ch)
      7'h64: n = '{1'b1, NAV_NEXT};
      7'h61: n = '{1'b1, NAV_PREV};
      7'h77: n = '{1'b1, NAV_UP};
      7'h73: n = '{1'b1, NAV_DOWN};
      default: n = '{1'b0, NAV_NEXT};
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

@@ src/kmd_front.sv @@
// Front end: splits the event byte, finds the key table cell and classifies the item.
// Depends on kmd_pkg.
`default_nettype none

module kmd_front
  import kmd_pkg::*;
#(
  parameter int unsigned KEY_ROWS = 4,
  parameter int unsigned KEY_COLS = 10
) (
  input  wire logic        kind_i,
  input  wire logic [7:0]  event_code_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic        select_held_i,
  input  wire logic        wake_swallow_i,
  output kmd_item_t        item_o
);

  logic [6:0] key_num;
  logic [6:0] idx;
  logic [2:0] row;
  logic [3:0] col;
  logic       in_range;
  kmd_cell_t  slot;

  assign key_num = event_code_i[6:0];
  assign idx     = key_num - 7'd1;

  // Row and column by comparing against the row start offsets
  always_comb begin
    row = '0;
    col = idx[3:0];
    for (int r = 1; r < KEY_ROWS; r++) begin
      if (idx >= 7'(r * KEY_COLS)) begin
        row = 3'(r);
        col = 4'(idx - 7'(r * KEY_COLS));
      end
    end
  end

  // key number zero wraps idx to 127, caught by the explicit zero test
  assign in_range = (key_num != 7'd0) && ({1'b0, idx} < 8'(KEY_ROWS * KEY_COLS));
  assign slot     = key_cell(row, col);

  always_comb begin
    item_o.slot         = slot;
    item_o.pressed      = event_code_i[7];
    item_o.now_ms       = now_ms_i;
    item_o.select_held  = select_held_i;
    item_o.wake_swallow = wake_swallow_i;
    if (kind_i) begin
      item_o.cls = CLS_POLL;
    end else if (!in_range) begin
      item_o.cls = CLS_DROP;
    end else if (slot.plain == CH_FN) begin
      item_o.cls = CLS_FN;
    end else if (slot.plain == CH_SHIFT) begin
      item_o.cls = CLS_SHIFT;
    end else begin
      item_o.cls = CLS_CHAR;
    end
  end

endmodule

`default_nettype wire

@@ src/kmd_queue.sv @@
// Short queue of classified items between front and back.
// Depends on kmd_pkg for the item type and depth.
`default_nettype none

module kmd_queue
  import kmd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_valid_i,
  output logic           push_ready_o,
  input  wire kmd_item_t push_item_i,
  output logic           pop_valid_o,
  input  wire logic      pop_ready_i,
  output kmd_item_t      pop_item_o
);

  kmd_item_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

@@ src/kmd_back.sv @@
// Back end: modifier latches, layer select, navigation repeat timers, poll summary
// and the result register. Holds the configuration registers. Depends on kmd_pkg.
`default_nettype none

module kmd_back
  import kmd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0]          cfg_data_i,
  input  wire logic                 item_valid_i,
  output logic                      item_ready_o,
  input  wire kmd_item_t            item_i,
  output logic                      res_valid_o,
  input  wire logic                 res_ready_i,
  output logic                      res_kind_o,
  output kmd_result_t               res_o
);

  logic [15:0]   start_q, period_q;
  logic          fn_q, fn_d;
  logic          shift_q, shift_d;
  logic          caps_q, caps_d;
  logic [3:0]    held_q, held_d;
  logic [31:0]   dl_q [NAV_LANES];
  logic [31:0]   dl_d [NAV_LANES];
  logic [PP_W-1:0] pulses_q, pulses_d;
  logic          out_valid_q, out_valid_d;
  logic          out_kind_q;
  kmd_result_t   out_q;

  logic          is_poll;
  logic          out_free;
  logic          pop;
  logic          produce;
  logic          emit_char;
  logic [6:0]    ch;
  kmd_nav_t      nav;
  logic [31:0]   dl_sum;
  logic [3:0]    hits;
  logic [PP_W-1:0] summ;
  kmd_result_t   res_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= RESET_REPEAT_START;
      period_q <= RESET_REPEAT_PERIOD;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_REPEAT_START) begin
        start_q <= cfg_data_i;
      end else if (cfg_index_i == REG_REPEAT_PERIOD) begin
        period_q <= cfg_data_i;
      end
    end
  end

  assign is_poll  = (item_i.cls == CLS_POLL);
  assign out_free = !out_valid_q || res_ready_i;

  // Layer select: fn over shift^caps over plain
  always_comb begin
    if (fn_q) begin
      ch = item_i.slot.alt;
    end else if (shift_q != caps_q) begin
      ch = item_i.slot.shifted;
    end else begin
      ch = item_i.slot.plain;
    end
  end

  assign nav       = nav_decode(ch);
  assign emit_char = (item_i.cls == CLS_CHAR) && item_i.pressed && !item_i.wake_swallow
                     && (ch != 7'd0);
  assign produce   = is_poll || emit_char;
  assign pop       = item_valid_i && (!produce || out_free);
  assign item_ready_o = !produce || out_free;

  // One adder serves both the press deadline and the repeat reload
  assign dl_sum = item_i.now_ms + {16'd0, (is_poll ? period_q : start_q)};

  always_comb begin
    for (int i = 0; i < NAV_LANES; i++) begin
      hits[i] = is_poll && held_q[i] && (item_i.now_ms >= dl_q[i]);
    end
  end

  assign summ = pulses_q | {3'd0, hits};

  always_comb begin
    fn_d     = fn_q;
    shift_d  = shift_q;
    caps_d   = caps_q;
    held_d   = held_q;
    pulses_d = pulses_q;
    for (int i = 0; i < NAV_LANES; i++) begin
      dl_d[i] = dl_q[i];
    end
    if (pop) begin
      unique case (item_i.cls)
        CLS_FN: begin
          fn_d = !fn_q;
        end
        CLS_SHIFT: begin
          shift_d = item_i.pressed;
          if (fn_q && item_i.pressed) begin
            caps_d = !caps_q;
          end
        end
        CLS_CHAR: begin
          if (emit_char) begin
            pulses_d[PP_KEY] = 1'b1;
            if (ch == CH_BKSP) pulses_d[PP_ESC] = 1'b1;
            if (ch == CH_ENTER) pulses_d[PP_SEL] = 1'b1;
            if (nav.hit) begin
              pulses_d[nav.lane] = 1'b1;
              dl_d[nav.lane]     = dl_sum;
            end
          end
          // held flag follows the key even when the press is swallowed
          if (nav.hit) begin
            held_d[nav.lane] = item_i.pressed;
          end
        end
        CLS_POLL: begin
          pulses_d = '0;
          for (int i = 0; i < NAV_LANES; i++) begin
            if (hits[i]) dl_d[i] = dl_sum;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_d = '0;
    if (is_poll) begin
      res_d.next_pulse = summ[NAV_NEXT];
      res_d.prev_pulse = summ[NAV_PREV];
      res_d.up_pulse   = summ[NAV_UP];
      res_d.down_pulse = summ[NAV_DOWN];
      res_d.sel_pulse  = summ[PP_SEL];
      res_d.esc_pulse  = summ[PP_ESC];
      res_d.key_pulse  = summ[PP_KEY];
      res_d.clear_keys = !(summ[PP_KEY] || (summ[3:0] != 4'd0));
      res_d.any_press  = (summ != '0);
    end else begin
      res_d.char_code = ch;
      res_d.fn_mod    = item_i.select_held;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = pop && produce;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fn_q        <= 1'b0;
      shift_q     <= 1'b0;
      caps_q      <= 1'b0;
      held_q      <= '0;
      pulses_q    <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NAV_LANES; i++) begin
        dl_q[i] <= '0;
      end
    end else begin
      fn_q        <= fn_d;
      shift_q     <= shift_d;
      caps_q      <= caps_d;
      held_q      <= held_d;
      pulses_q    <= pulses_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < NAV_LANES; i++) begin
        dl_q[i] <= dl_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && produce) begin
      out_kind_q <= is_poll;
      out_q      <= res_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_kind_o  = out_kind_q;
  assign res_o       = out_q;

`ifndef ASSERT_OFF
  a_poll_clears_pulses : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && is_poll |=> pulses_q == '0)
    else $error("pulse register not cleared after summary");

  a_char_sets_key : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && emit_char |=> pulses_q[PP_KEY])
    else $error("character emitted without key pulse");

  a_caps_only_on_shift : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(caps_q) |-> $past(pop && item_i.cls == CLS_SHIFT && fn_q))
    else $error("caps lock changed without fn+shift");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_ready_i |=> out_valid_q && $stable(out_q))
    else $error("pending result overwritten");

  a_summary_no_char : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_q |-> out_q.char_code == 7'd0 && !out_q.fn_mod)
    else $error("summary carries character data");
`endif

endmodule

`default_nettype wire

@@ src/keymatrix_decode_autorepeat.sv @@
// Top level of the key-matrix decoder with navigation auto-repeat.
// Depends on kmd_pkg, kmd_front, kmd_queue and kmd_back.
`default_nettype none

// Takes one item per clock on the input stream while the queue has room, and gives at
// most one result per item. A classified item waits in a two-entry queue; the back
// end retires one queued item per cycle, so sustained throughput is one item per
// clock whenever the output side takes results as fast. An accepted item is
// registered in the queue, then its result in the result register. Items that give
// no result (dropped codes, fn, shift, swallowed or released keys) retire even while
// a result waits to be taken. tuser on the input is the item kind (1 = end of poll);
// tuser on the output is the result kind (1 = poll summary, 0 = character).
// Navigation deadlines are plain unsigned 32-bit compares, so a time wrap is not
// handled. Configuration must be written only while the block is idle; the block
// does not enforce it. Writes to an index past the second register are ignored.
module keymatrix_decode_autorepeat
  import kmd_pkg::*;
#(
  parameter int unsigned KEY_ROWS = 4,
  parameter int unsigned KEY_COLS = 10
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0]          cfg_data_i,
  // input stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // event_code[7:0], now_ms[39:8], select_held[40], wake_swallow[41], zero fill
  input  wire logic [47:0]          s_axis_tdata,
  // kind[0]
  input  wire logic                 s_axis_tuser,
  // result stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // char_code[6:0], fn_mod[7], next_pulse[8], prev_pulse[9], up_pulse[10],
  // down_pulse[11], sel_pulse[12], esc_pulse[13], key_pulse[14], clear_keys[15],
  // any_press[16], zero fill
  output logic [23:0]               m_axis_tdata,
  // result_kind[0]
  output logic                      m_axis_tuser
);

  kmd_item_t   front_item;
  kmd_item_t   queue_item;
  logic        queue_valid;
  logic        back_ready;
  kmd_result_t result;

  // Front: pure decode, the queue registers it
  kmd_front #(
    .KEY_ROWS (KEY_ROWS),
    .KEY_COLS (KEY_COLS)
  ) u_front (
    .kind_i         (s_axis_tuser),
    .event_code_i   (s_axis_tdata[7:0]),
    .now_ms_i       (s_axis_tdata[39:8]),
    .select_held_i  (s_axis_tdata[40]),
    .wake_swallow_i (s_axis_tdata[41]),
    .item_o         (front_item)
  );

  kmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid),
    .push_ready_o (s_axis_tready),
    .push_item_i  (front_item),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (back_ready),
    .pop_item_o   (queue_item)
  );

  // Back: state update and result register
  kmd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (queue_valid),
    .item_ready_o (back_ready),
    .item_i       (queue_item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_kind_o   (m_axis_tuser),
    .res_o        (result)
  );

  assign m_axis_tdata = {7'd0, result};

endmodule

`default_nettype wire

@@ tb/sv/tb_keymatrix_decode_autorepeat.sv @@
// Self-checking testbench for the key-matrix decoder with navigation auto-repeat.
// Needs kmd_pkg and keymatrix_decode_autorepeat; the predictor lives in the class below.
`default_nettype none

module tb_keymatrix_decode_autorepeat
  import kmd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RESET_CYCLES   = 4;
  localparam int unsigned SETTLE_CYCLES  = 4;     // lets result-less items drain after the last result
  localparam int unsigned LONG_HOLD      = 300;   // sink back-pressure stretch
  localparam int unsigned WATCHDOG_LIMIT = 5000;  // cycles without any transfer
  localparam int unsigned PHASE_ITEMS    = 185;
  localparam int unsigned PHASES         = 6;

  // Spare register indexes: writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  // One-based key numbers of the 4x10 matrix
  localparam logic [7:0] PRESS     = 8'h80;
  localparam logic [6:0] KEY_Q     = 7'd1;
  localparam logic [6:0] KEY_W     = 7'd2;
  localparam logic [6:0] KEY_A     = 7'd11;
  localparam logic [6:0] KEY_S     = 7'd12;
  localparam logic [6:0] KEY_D     = 7'd13;
  localparam logic [6:0] KEY_RET   = 7'd20;
  localparam logic [6:0] KEY_FN    = 7'd21;
  localparam logic [6:0] KEY_SHIFT = 7'd29;
  localparam logic [6:0] KEY_BKSP  = 7'd30;
  localparam logic [6:0] KEY_SPACE = 7'd31;
  localparam logic [6:0] KEY_LAST  = 7'd40;  // last cell, empty

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_CYCLIC} sink_mode_e;

  // ---------------------------------------------------------------------------
  // Keymap predictor and expected-result store
  // ---------------------------------------------------------------------------
  class keymap_scoreboard;
    localparam int unsigned CELLS = 40;

    typedef struct packed {
      logic        summary;
      kmd_result_t body;
    } key_result_t;

    logic [15:0]  repeat_start;
    logic [15:0]  repeat_period;
    bit           fn_latch;
    bit           shift_down;
    bit           caps_on;
    bit [3:0]     nav_held;
    bit [31:0]    nav_deadline [NAV_LANES];
    bit [6:0]     poll_pulses;
    byte unsigned plain_ch [CELLS];
    byte unsigned shift_ch [CELLS];
    byte unsigned alt_ch   [CELLS];
    key_result_t  due_results [$];
    int unsigned  errors;
    int unsigned  results_seen;

    function new();
      string row_a, row_b, alt_a, alt_b;
      int i;
      row_a = "qwertyuiopasdfghjkl";
      row_b = "zxcvbnm";
      alt_a = "1234567890*/+-=:'\"@";
      alt_b = "_$;?!,.";
      for (i = 0; i < CELLS; i++) begin
        plain_ch[i] = 0;
        shift_ch[i] = 0;
        alt_ch[i]   = 0;
      end
      for (i = 0; i < 19; i++) begin
        plain_ch[i] = row_a[i];
        shift_ch[i] = (plain_ch[i] >= "a") ? plain_ch[i] - 8'h20 : plain_ch[i];
        alt_ch[i]   = alt_a[i];
      end
      for (i = 0; i < 7; i++) begin
        plain_ch[21+i] = row_b[i];
        shift_ch[21+i] = row_b[i] - 8'h20;
        alt_ch[21+i]   = alt_b[i];
      end
      plain_ch[19] = CH_ENTER; shift_ch[19] = CH_ENTER; alt_ch[19] = CH_ENTER;
      plain_ch[20] = CH_FN;    shift_ch[20] = CH_FN;    alt_ch[20] = CH_FN;
      plain_ch[28] = CH_SHIFT; shift_ch[28] = CH_SHIFT; alt_ch[28] = 8'h00;
      plain_ch[29] = CH_BKSP;  shift_ch[29] = CH_BKSP;  alt_ch[29] = CH_BKSP;
      plain_ch[30] = " ";      shift_ch[30] = " ";      alt_ch[30] = " ";
      repeat_start  = RESET_REPEAT_START;
      repeat_period = RESET_REPEAT_PERIOD;
      fn_latch = 0;
      shift_down = 0;
      caps_on = 0;
      nav_held = '0;
      poll_pulses = '0;
      foreach (nav_deadline[j]) nav_deadline[j] = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
      case (idx)
        REG_REPEAT_START:  repeat_start = data;
        REG_REPEAT_PERIOD: repeat_period = data;
        default: ;
      endcase
    endfunction

    // d/a/w/s steer next/prev/up/down; -1 for anything else
    function int nav_lane(byte unsigned ch);
      case (ch)
        "d":     return NAV_NEXT;
        "a":     return NAV_PREV;
        "w":     return NAV_UP;
        "s":     return NAV_DOWN;
        default: return -1;
      endcase
    endfunction

    // Advance the predicted state by one accepted item and queue its result, if it gives one
    function void note_item(bit poll, logic [7:0] code, logic [31:0] now, bit sel,
                            bit swallow);
      key_result_t  r;
      int           lane;
      int unsigned  idx;
      byte unsigned ch;
      r = '0;
      if (poll) begin
        for (lane = 0; lane < NAV_LANES; lane++) begin
          if (nav_held[lane] && now >= nav_deadline[lane]) begin
            poll_pulses[lane]  = 1'b1;
            nav_deadline[lane] = now + 32'(repeat_period);
          end
        end
        r.summary         = 1'b1;
        r.body.next_pulse = poll_pulses[NAV_NEXT];
        r.body.prev_pulse = poll_pulses[NAV_PREV];
        r.body.up_pulse   = poll_pulses[NAV_UP];
        r.body.down_pulse = poll_pulses[NAV_DOWN];
        r.body.sel_pulse  = poll_pulses[PP_SEL];
        r.body.esc_pulse  = poll_pulses[PP_ESC];
        r.body.key_pulse  = poll_pulses[PP_KEY];
        r.body.clear_keys = (poll_pulses[3:0] == 0) && !poll_pulses[PP_KEY];
        r.body.any_press  = |poll_pulses;
        poll_pulses = '0;
        due_results.insert(due_results.size(), r);
        return;
      end
      // key number zero or past the table: dropped without a trace
      if (code[6:0] == 0 || code[6:0] > CELLS) return;
      idx = code[6:0] - 1;
      if (plain_ch[idx] == CH_FN) begin
        fn_latch = !fn_latch;
        return;
      end
      if (plain_ch[idx] == CH_SHIFT) begin
        shift_down = code[7];
        if (fn_latch && shift_down) caps_on = !caps_on;
        return;
      end
      if (fn_latch) ch = alt_ch[idx];
      else if (shift_down != caps_on) ch = shift_ch[idx];
      else ch = plain_ch[idx];
      ch &= 8'h7f;
      lane = nav_lane(ch);
      if (code[7] && !swallow && ch != 0) begin
        if (ch == CH_BKSP) poll_pulses[PP_ESC] = 1'b1;
        if (ch == CH_ENTER) poll_pulses[PP_SEL] = 1'b1;
        if (lane >= 0) begin
          poll_pulses[lane]  = 1'b1;
          nav_deadline[lane] = now + 32'(repeat_start);
        end
        poll_pulses[PP_KEY] = 1'b1;
        r.body.char_code = ch[6:0];
        r.body.fn_mod    = sel;
        due_results.insert(due_results.size(), r);
      end
      // held flag follows the press even for a swallowed key
      if (lane >= 0) nav_held[lane] = code[7];
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task cmp_field(string name, logic [6:0] got, logic [6:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %h want %h", results_seen, name, got, want));
    endtask

    task check_result(logic summary, logic [23:0] data);
      key_result_t want;
      kmd_result_t got;
      results_seen++;
      if (due_results.size() == 0) begin
        report($sformatf("result %0d unexpected, kind %b data %h", results_seen,
                         summary, data));
        return;
      end
      want = due_results.pop_front();
      got  = kmd_result_t'(data[$bits(kmd_result_t)-1:0]);
      cmp_field("result_kind", 7'(summary), 7'(want.summary));
      cmp_field("char_code", got.char_code, want.body.char_code);
      cmp_field("fn_mod", 7'(got.fn_mod), 7'(want.body.fn_mod));
      cmp_field("next_pulse", 7'(got.next_pulse), 7'(want.body.next_pulse));
      cmp_field("prev_pulse", 7'(got.prev_pulse), 7'(want.body.prev_pulse));
      cmp_field("up_pulse", 7'(got.up_pulse), 7'(want.body.up_pulse));
      cmp_field("down_pulse", 7'(got.down_pulse), 7'(want.body.down_pulse));
      cmp_field("sel_pulse", 7'(got.sel_pulse), 7'(want.body.sel_pulse));
      cmp_field("esc_pulse", 7'(got.esc_pulse), 7'(want.body.esc_pulse));
      cmp_field("key_pulse", 7'(got.key_pulse), 7'(want.body.key_pulse));
      cmp_field("clear_keys", 7'(got.clear_keys), 7'(want.body.clear_keys));
      cmp_field("any_press", 7'(got.any_press), 7'(want.body.any_press));
      cmp_field("zero fill", data[23:17], 7'd0);
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [15:0]          cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [47:0]          s_axis_tdata;   // event_code, now_ms, select_held, wake_swallow
  logic                 s_axis_tuser;   // kind
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [23:0]          m_axis_tdata;   // char_code, fn_mod, pulse flags
  logic                 m_axis_tuser;   // result_kind

  keymatrix_decode_autorepeat dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5ns clk_i = ~clk_i;

  keymap_scoreboard book;

  // Stimulus-side bookkeeping
  logic [31:0] clock_ms;        // running millisecond clock fed to now_ms
  int unsigned burst_left;      // items left in the current sender burst
  int unsigned items_sent;      // accepted items that the block acts on
  int unsigned hold_gen;        // bumped to ask the sink for a long hold-off
  logic [15:0] rep_start_cur;
  logic [15:0] rep_period_cur;
  // Shadow of the modifier latches, only used to steer stimulus
  bit          fn_shadow, shift_shadow, caps_shadow;
  int unsigned idle_cycles;

  // ---------------------------------------------------------------------------
  // Monitor and watchdog. Everything is sampled at the rising edge, so both
  // sides see pre-edge values regardless of process order.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) book.write_reg(cfg_index_i, cfg_data_i);
      // note the input before checking: inputs always precede their results
      if (s_axis_tvalid && s_axis_tready)
        book.note_item(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[39:8],
                       s_axis_tdata[40], s_axis_tdata[41]);
      if (m_axis_tvalid && m_axis_tready) book.check_result(m_axis_tuser, m_axis_tdata);
      if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_keymatrix_decode_autorepeat: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: segments of free flow, coin-flip, sparse and cyclic stalls,
  // plus a long hold-off whenever the stimulus bumps hold_gen.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned seg_left, stall_left, hold_seen, tick;
    mode = RX_FREE;
    seg_left = 0;
    stall_left = 0;
    hold_seen = 0;
    tick = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_gen != hold_seen) begin
        hold_seen  = hold_gen;
        stall_left = LONG_HOLD;
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = sink_mode_e'($urandom_range(0, 3));
          seg_left = $urandom_range(8, 80);
        end
        seg_left--;
        case (mode)
          RX_FREE:   m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          RX_CYCLIC: m_axis_tready <= (tick % 3) != 0;
          default:   m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------------

  // Offer one item and hold it until the transfer. Bursts of random length
  // are separated by random gaps; now and then a long burst runs gap-free.
  task automatic drive_item(bit poll, logic [7:0] code, logic [31:0] now, bit sel,
                            bit swallow);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= poll;
    s_axis_tdata  <= {6'b0, swallow, sel, now, code};
    do @(posedge clk_i); while (!s_axis_tready);
    if (poll || (code[6:0] != 0 && code[6:0] <= KEY_LAST)) items_sent++;
    if (!poll && code[6:0] == KEY_FN) fn_shadow = !fn_shadow;
    if (!poll && code[6:0] == KEY_SHIFT) begin
      shift_shadow = code[7];
      if (fn_shadow && shift_shadow) caps_shadow = !caps_shadow;
    end
  endtask

  task automatic send_key(logic [6:0] num, bit pressed);
    clock_ms += $urandom_range(0, 20);
    drive_item(1'b0, {pressed, num}, clock_ms, $urandom_range(0, 3) == 0,
               $urandom_range(0, 9) == 0);
  endtask

  // End of poll; the unused event fields carry junk on purpose
  task automatic send_poll(int unsigned step_max);
    if ($urandom_range(0, 49) == 0) clock_ms = $urandom();
    else clock_ms += $urandom_range(0, step_max);
    drive_item(1'b1, 8'($urandom()), clock_ms, 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
  endtask

  // Poll spacing scaled to the repeat settings so deadlines get crossed
  function automatic int unsigned time_span();
    return ((rep_start_cur > rep_period_cur) ? rep_start_cur : rep_period_cur) / 2 + 16;
  endfunction

  function automatic logic [6:0] nav_key();
    case ($urandom_range(0, 3))
      0:       return KEY_D;
      1:       return KEY_A;
      2:       return KEY_W;
      default: return KEY_S;
    endcase
  endfunction

  // Weighted toward navigation keys and the special cells
  function automatic logic [6:0] any_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return nav_key();
    if (r < 38) return KEY_RET;
    if (r < 46) return KEY_BKSP;
    if (r < 52) return KEY_FN;
    if (r < 58) return KEY_SHIFT;
    return 7'($urandom_range(1, KEY_LAST));
  endfunction

  // Bring fn off and shift equal to caps so the plain layer is active
  task automatic plain_layer();
    if (fn_shadow) send_key(KEY_FN, 1'($urandom_range(0, 1)));
    if (shift_shadow != caps_shadow) send_key(KEY_SHIFT, caps_shadow);
  endtask

  task automatic random_scenario();
    int unsigned pick, n;
    logic [6:0]  key;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      // hold a navigation key across several polls, then let go
      if ($urandom_range(0, 4) != 0) plain_layer();
      key = nav_key();
      send_key(key, 1'b1);
      n = $urandom_range(1, 8);
      repeat (n) begin
        if ($urandom_range(0, 4) == 0) send_key(any_key(), 1'($urandom_range(0, 1)));
        send_poll(time_span());
      end
      send_key(key, 1'b0);
      send_poll(time_span());
    end else if (pick < 60) begin
      // typing burst
      n = $urandom_range(1, 5);
      repeat (n) begin
        key = any_key();
        send_key(key, 1'b1);
        if ($urandom_range(0, 2) != 0) send_key(key, 1'b0);
      end
      send_poll(time_span());
    end else if (pick < 72) begin
      send_key(($urandom_range(0, 1) != 0) ? KEY_FN : KEY_SHIFT, 1'($urandom_range(0, 1)));
    end else if (pick < 85) begin
      send_poll(time_span());
    end else begin
      // noise: any kind, any code, any time
      drive_item(1'($urandom_range(0, 1)), 8'($urandom()), $urandom(),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Drop valid, wait for every expected result, then let result-less items
  // still in the pipeline drain out
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (book.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  // Leaves cfg_valid_i high so back-to-back writes need no second assignment
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure(logic [15:0] start, logic [15:0] period, bit spare);
    settle();
    cfg_write(REG_REPEAT_START, start);
    cfg_write(REG_REPEAT_PERIOD, period);
    if (spare) begin
      cfg_write(REG_SPARE_LO, 16'($urandom()));
      cfg_write(REG_SPARE_HI, 16'($urandom()));
    end
    cfg_valid_i <= 1'b0;
    rep_start_cur  = start;
    rep_period_cur = period;
  endtask

  // Sink holds off for a long stretch while the sender keeps pushing polls and key
  // presses, mostly result-producing: the queue fills and s_axis_tready must drop.
  task automatic flood_while_blocked();
    hold_gen   <= hold_gen + 1;
    burst_left = 40;
    repeat (24) begin
      if ($urandom_range(0, 1) != 0) send_poll(8);
      else send_key(7'($urandom_range(KEY_Q, KEY_RET)), 1'b1);
    end
  endtask

  // Directed opening: dropped codes, empty cell, every special key and layer,
  // swallowed press, repeat deadline edge, time extremes.
  task automatic directed_checks();
    drive_item(1'b0, PRESS, 32'd0, 1'b0, 1'b0);                   // key number zero
    drive_item(1'b0, 8'h00, 32'd0, 1'b1, 1'b1);
    drive_item(1'b0, PRESS | 8'(KEY_LAST + 1), 32'd5, 1'b0, 1'b0); // past the table
    drive_item(1'b0, 8'hFF, 32'd6, 1'b1, 1'b0);
    drive_item(1'b0, PRESS | KEY_LAST, 32'd7, 1'b0, 1'b0);         // empty cell
    drive_item(1'b0, PRESS | KEY_Q, 32'd10, 1'b1, 1'b0);
    drive_item(1'b0, {1'b0, KEY_Q}, 32'd11, 1'b0, 1'b0);           // release: no char
    drive_item(1'b0, PRESS | KEY_RET, 32'd12, 1'b0, 1'b0);
    drive_item(1'b0, PRESS | KEY_BKSP, 32'd13, 1'b0, 1'b0);
    drive_item(1'b1, 8'hFF, 32'd0, 1'b1, 1'b1);                    // sel + esc + key
    drive_item(1'b0, PRESS | KEY_W, 32'd1000, 1'b0, 1'b1);         // swallowed, still held
    drive_item(1'b1, 8'h00, 32'd1349, 1'b0, 1'b0);
    drive_item(1'b0, PRESS | KEY_D, 32'd2000, 1'b0, 1'b0);
    drive_item(1'b1, 8'h00, 32'd2349, 1'b0, 1'b0);                 // one short of repeat
    drive_item(1'b1, 8'h00, 32'd2350, 1'b0, 1'b0);                 // repeat fires
    drive_item(1'b0, {1'b0, KEY_W}, 32'd2400, 1'b0, 1'b0);
    drive_item(1'b0, {1'b0, KEY_D}, 32'd2401, 1'b0, 1'b0);
    drive_item(1'b0, PRESS | KEY_SHIFT, 32'd2500, 1'b0, 1'b0);
    drive_item(1'b0, PRESS | KEY_A, 32'd2501, 1'b0, 1'b0);         // 'A', not navigation
    drive_item(1'b0, PRESS | KEY_FN, 32'd2502, 1'b0, 1'b0);
    drive_item(1'b0, PRESS | KEY_SHIFT, 32'd2503, 1'b0, 1'b0);     // fn + shift: caps
    drive_item(1'b0, PRESS | KEY_D, 32'd2504, 1'b1, 1'b0);         // fn layer
    drive_item(1'b0, {1'b0, KEY_FN}, 32'd2505, 1'b0, 1'b0);        // release toggles too
    drive_item(1'b0, {1'b0, KEY_SHIFT}, 32'd2506, 1'b0, 1'b0);
    drive_item(1'b0, PRESS | KEY_SPACE, 32'hFFFF_FFFF, 1'b1, 1'b0);
    drive_item(1'b1, 8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase, target;
    book = new();
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    clock_ms      = '0;
    burst_left    = 0;
    items_sent    = 0;
    hold_gen      = 0;
    idle_cycles   = 0;
    fn_shadow     = 0;
    shift_shadow  = 0;
    caps_shadow   = 0;
    rep_start_cur  = RESET_REPEAT_START;
    rep_period_cur = RESET_REPEAT_PERIOD;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_checks();

    // Phase 0 runs on the reset values; later phases cover both extremes,
    // random settings and ignored register indexes
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        1: configure(16'd0, 16'd0, 1'b0);
        2: configure(16'hFFFF, 16'hFFFF, 1'b1);
        3: configure(16'($urandom()), 16'($urandom()), 1'b0);
        4: configure(16'($urandom_range(0, 400)), 16'($urandom_range(0, 200)), 1'b1);
        5: configure(16'd1, 16'hFFFF, 1'b0);
        default: ;
      endcase
      flood_while_blocked();
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) random_scenario();
    end

    settle();
    if (book.errors == 0 && book.pending() == 0) begin
      $display("tb_keymatrix_decode_autorepeat: done, clean");
    end else begin
      $display("tb_keymatrix_decode_autorepeat: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
src/kmd_pkg.sv
src/kmd_front.sv
src/kmd_queue.sv
src/kmd_back.sv
src/keymatrix_decode_autorepeat.sv
tb/sv/tb_keymatrix_decode_autorepeat.sv
